// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro takes a label, clock, reset, and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/cir_pkg.sv =====
// Package for the color index to RGB block: index region codes and constant tables.
// No dependencies.
`timescale 1ns / 1ps

package cir_pkg;

   localparam logic [7:0] UNIV_FIRST = 8'd10;
   localparam logic [7:0] GRAY_FIRST = 8'd250;

   localparam logic [1:0] REGION_FIXED = 2'd0;
   localparam logic [1:0] REGION_UNIV  = 2'd1;
   localparam logic [1:0] REGION_GRAY  = 2'd2;

   localparam int CHANNELS = 3;

   typedef logic [7:0] chan_type;

   // Fixed entries 0..9 as {red, green, blue}.
   function automatic logic [23:0] fixed_rgb(input logic [3:0] idx);
      logic [23:0] rgb;
      case (idx)
         4'd0:    rgb = 24'h000000;
         4'd1:    rgb = 24'hff0000;
         4'd2:    rgb = 24'hffff00;
         4'd3:    rgb = 24'h00ff00;
         4'd4:    rgb = 24'h00ffff;
         4'd5:    rgb = 24'h0000ff;
         4'd6:    rgb = 24'hff00ff;
         4'd7:    rgb = 24'h0f0f0f;
         4'd8:    rgb = 24'h808080;
         4'd9:    rgb = 24'hc0c0c0;
         default: rgb = 24'h000000;
      endcase
      return rgb;
   endfunction

   // Median channel level 255*mag/4.
   function automatic chan_type med_level(input logic [2:0] mag);
      chan_type lvl;
      case (mag)
         3'd0:    lvl = 8'd0;
         3'd1:    lvl = 8'd63;
         3'd2:    lvl = 8'd127;
         3'd3:    lvl = 8'd191;
         3'd4:    lvl = 8'd255;
         default: lvl = 8'd0;
      endcase
      return lvl;
   endfunction

   function automatic logic [1:0] inc_mod3(input logic [1:0] a);
      return (a == 2'd2) ? 2'd0 : a + 2'd1;
   endfunction

endpackage

// ===== rtl/color_index_to_rgb.sv =====
// Color index to RGB palette expansion, four register stages.
// Depends on cir_pkg.
`timescale 1ns / 1ps

// Translates an 8-bit drawing color index into 8-bit red, green and blue.
// One item is accepted per clock while no stall holds the stages. An item
// passes through four register stages: index decode at the accepting edge,
// then hue/channel select, desaturate and scale, and divide by five into the
// output register. Each stage holds its own valid bit and advances whenever
// the stage after it is empty or moving, so a stall on rsp_ready backs up
// through the stages without dropping or repeating anything and bubbles are
// squeezed out.
module color_index_to_rgb
   import cir_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_color_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue
);

   // stage valids and readies
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic s1_ready, s2_ready, s3_ready, out_ready;

   assign out_ready = !out_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready)  s1_valid_ff  <= req_valid;
         if (s2_ready)  s2_valid_ff  <= s1_valid_ff;
         if (s3_ready)  s3_valid_ff  <= s2_valid_ff;
         if (out_ready) out_valid_ff <= s3_valid_ff;
      end
   end

   // ---- stage 1: region, hue = k/10, rem = k%10 ----
   logic [1:0]  s1_region_ff, s1_region_in;
   logic [7:0]  s1_index_ff;
   logic [4:0]  s1_hue_ff, s1_hue_in;
   logic [3:0]  s1_rem_ff, s1_rem_in;
   logic [7:0]  k;
   logic [15:0] k_x205;
   logic [7:0]  hue_x10;

   always_comb begin
      k       = req_color_index - UNIV_FIRST;
      // k/10 as (k*205)>>11, exact for k < 250
      k_x205  = 16'(k) * 16'd205;
      s1_hue_in = k_x205[15:11];
      hue_x10 = {s1_hue_in, 3'b000} + {2'b00, s1_hue_in, 1'b0};
      s1_rem_in = 4'(k - hue_x10);
      if (req_color_index < UNIV_FIRST)
         s1_region_in = REGION_FIXED;
      else if (req_color_index < GRAY_FIRST)
         s1_region_in = REGION_UNIV;
      else
         s1_region_in = REGION_GRAY;
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_region_ff <= s1_region_in;
         s1_index_ff  <= req_color_index;
         s1_hue_ff    <= s1_hue_in;
         s1_rem_ff    <= s1_rem_in;
      end
   end

   // ---- stage 2: pick max/median/min channels, value and desat flag ----
   chan_type    s2_chan_ff [CHANNELS];
   chan_type    s2_chan_in [CHANNELS];
   logic [2:0]  s2_value_ff, s2_value_in;
   logic        s2_desat_ff, s2_desat_in;
   logic [1:0]  hue_grp, mx, med;
   logic signed [5:0] j_raw, j_adj;
   logic [2:0]  mag;
   chan_type    med_val, gray_val;
   logic [23:0] fixed_val;
   logic [2:0]  gray_n;
   logic [5:0]  hue_p3;

   always_comb begin
      hue_p3  = {1'b0, s1_hue_ff} + 6'd3;
      hue_grp = hue_p3[4:3];
      mx      = (hue_grp == 2'd3) ? 2'd0 : hue_grp;
      j_raw   = $signed({1'b0, s1_hue_ff}) - $signed({1'b0, mx, 3'b000});
      j_adj   = (j_raw > 6'sd4) ? j_raw - 6'sd24 : j_raw;
      if (j_adj < 6'sd0) begin
         mag = 3'(-j_adj);
         med = inc_mod3(inc_mod3(mx));
      end else begin
         mag = 3'(j_adj);
         med = inc_mod3(mx);
      end
      med_val   = med_level(mag);
      fixed_val = fixed_rgb(s1_index_ff[3:0]);
      gray_n    = 3'(s1_index_ff - GRAY_FIRST);
      gray_val  = 8'(9'd65 + 9'(gray_n) * 9'd38);

      s2_value_in = 3'd5;
      s2_desat_in = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         s2_chan_in[c] = gray_val;
      end
      case (s1_region_ff)
         REGION_FIXED: begin
            s2_chan_in[0] = fixed_val[23:16];
            s2_chan_in[1] = fixed_val[15:8];
            s2_chan_in[2] = fixed_val[7:0];
         end
         REGION_UNIV: begin
            s2_value_in = 3'd5 - 3'(s1_rem_ff[3:1]);
            s2_desat_in = s1_rem_ff[0];
            for (int c = 0; c < CHANNELS; c++) begin
               if (2'(c) == mx)
                  s2_chan_in[c] = 8'd255;
               else if (2'(c) == med)
                  s2_chan_in[c] = med_val;
               else
                  s2_chan_in[c] = 8'd0;
            end
         end
         default: ;  // gray levels set above
      endcase
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_chan_ff  <= s2_chan_in;
         s2_value_ff <= s2_value_in;
         s2_desat_ff <= s2_desat_in;
      end
   end

   // ---- stage 3: desaturate, multiply by value ----
   logic [10:0] s3_prod_ff [CHANNELS];
   logic [10:0] s3_prod_in [CHANNELS];
   chan_type    desat_c;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         desat_c = s2_desat_ff ? {1'b1, s2_chan_ff[c][7:1]} : s2_chan_ff[c];
         s3_prod_in[c] = 11'(desat_c) * 11'(s2_value_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_prod_ff <= s3_prod_in;
      end
   end

   // ---- output stage: divide by 5 as (x*205)>>10 ----
   // exact below 1024 and for multiples of five up to 1275, which covers
   // every product: anything above 1020 comes from a value of five
   chan_type    out_chan_ff [CHANNELS];
   chan_type    out_chan_in [CHANNELS];
   logic [17:0] quot_wide;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         quot_wide      = 18'(s3_prod_ff[c]) * 18'd205;
         out_chan_in[c] = quot_wide[17:10];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_chan_ff <= out_chan_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_red   = out_chan_ff[0];
   assign rsp_green = out_chan_ff[1];
   assign rsp_blue  = out_chan_ff[2];

endmodule

// ===== rtl/cir_checker.sv =====
// Port-level checks for color_index_to_rgb, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cir_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_color_index,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue
);

   // empty output register means the whole pipe can move
   `ASSERT_IMPLIES(a_ready_when_out_empty, clock, reset, !rsp_valid, req_ready)

   // nothing comes out right after reset
   `ASSERT_IMPLIES(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid)

   // an item with the output side open throughout shows up on rsp_valid
   `ASSERT_NEXT(a_latency, clock, reset,
      $past(req_valid && req_ready, 3) && $past(rsp_ready, 2) && $past(rsp_ready, 1)
      && rsp_ready && !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3),
      rsp_valid)

   // waiting input item holds
   `ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready,
      req_valid && $stable(req_color_index))

   // stalled item holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))

endmodule

bind color_index_to_rgb cir_checker u_cir_checker (.*);
